// ===== rtl/core/lsm_pkg.sv =====
// lsm_pkg: shared types, constants and helpers for the line substring matcher
// used by lsm_cfg, lsm_scan and line_substring_matcher; no dependencies
package lsm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PatBytes = 16;  // bytes held by the two pattern registers
  localparam int unsigned LenW     = 5;
  localparam int unsigned CntW     = 32;
  localparam int unsigned RegW     = 64;
  localparam int unsigned AddrW    = 5;

  localparam logic [ByteW-1:0] CharUpA    = 8'h41;
  localparam logic [ByteW-1:0] CharUpZ    = 8'h5A;
  localparam logic [ByteW-1:0] CaseOffset = 8'd32;
  localparam logic [ByteW-1:0] CharNl     = 8'h0A;
  localparam logic [ByteW-1:0] CharNul    = 8'h00;
  localparam logic [CntW-1:0]  CntMax     = {CntW{1'b1}};

  typedef enum logic [1:0] {
    RegPatLow  = 2'd0,
    RegPatHigh = 2'd1,
    RegPatLen  = 2'd2,
    RegIgnCase = 2'd3
  } lsm_reg_e;

  // pattern already folded and aligned to window positions (newest byte at 0)
  typedef struct packed {
    logic [PatBytes-1:0][ByteW-1:0] pat_al;
    logic [LenW-1:0]                plen;
    logic                           ign_case;
  } lsm_cfg_t;

  typedef struct packed {
    logic            line_valid;
    logic [CntW-1:0] line_number;
    logic            line_matched;
    logic [CntW-1:0] hit_count;
    logic            end_of_file;
  } lsm_result_t;

  function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c, input logic ign);
    logic [ByteW-1:0] r;
    r = c;
    if (ign && c >= CharUpA && c <= CharUpZ) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lsm_cfg.sv =====
// lsm_cfg: register file behind the configuration port, plus pattern alignment
// depends on lsm_pkg
module lsm_cfg #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsm_pkg::AddrW-1:0] paddr,
  input  logic [lsm_pkg::RegW-1:0]  pwdata,
  output logic [lsm_pkg::RegW-1:0]  prdata,
  output logic                      pready,
  output lsm_pkg::lsm_cfg_t         cfg_o
);

  logic [lsm_pkg::RegW-1:0] pat_low_q, pat_high_q;
  logic [lsm_pkg::LenW-1:0] plen_q;
  logic                     ign_q;
  logic                     wr_en;
  lsm_pkg::lsm_reg_e        reg_sel;
  logic [lsm_pkg::LenW-1:0] used_len;
  logic [lsm_pkg::PatBytes-1:0][lsm_pkg::ByteW-1:0] pat_bytes;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = lsm_pkg::lsm_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      plen_q     <= '0;
      ign_q      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        lsm_pkg::RegPatLow:  pat_low_q  <= pwdata;
        lsm_pkg::RegPatHigh: pat_high_q <= pwdata;
        lsm_pkg::RegPatLen:  plen_q     <= pwdata[lsm_pkg::LenW-1:0];
        lsm_pkg::RegIgnCase: ign_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lsm_pkg::RegPatLow:  prdata = pat_low_q;
      lsm_pkg::RegPatHigh: prdata = pat_high_q;
      lsm_pkg::RegPatLen:  prdata = {{(lsm_pkg::RegW-lsm_pkg::LenW){1'b0}}, plen_q};
      lsm_pkg::RegIgnCase: prdata = {{(lsm_pkg::RegW-1){1'b0}}, ign_q};
      default:             prdata = '0;
    endcase
  end

  assign used_len  = (plen_q > lsm_pkg::LenW'(PATTERN_MAX)) ? lsm_pkg::LenW'(PATTERN_MAX)
                                                            : plen_q;
  assign pat_bytes = {pat_high_q, pat_low_q};

  // window position k holds the newest byte at 0, so it meets pattern byte len-1-k
  always_comb begin
    logic [lsm_pkg::LenW-1:0] idx;
    cfg_o.plen     = used_len;
    cfg_o.ign_case = ign_q;
    for (int k = 0; k < lsm_pkg::PatBytes; k++) begin
      idx = used_len - lsm_pkg::LenW'(k) - lsm_pkg::LenW'(1);
      if (lsm_pkg::LenW'(k) < used_len) begin
        cfg_o.pat_al[k] = lsm_pkg::fold(pat_bytes[idx[3:0]], ign_q);
      end else begin
        cfg_o.pat_al[k] = '0;
      end
    end
  end

endmodule

// ===== rtl/core/lsm_scan.sv =====
// lsm_scan: line state, byte window and parallel pattern compare
// depends on lsm_pkg
module lsm_scan #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [lsm_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  input  lsm_pkg::lsm_cfg_t         cfg_i,
  output logic                      emit_o,
  output lsm_pkg::lsm_result_t      res_o
);

  localparam int unsigned BilW = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][lsm_pkg::ByteW-1:0] win_q, win_d, win_shift;
  logic [BilW-1:0]          bil_q, bil_d, bil_inc;
  logic                     hit_q, hit_d;
  logic [lsm_pkg::CntW-1:0] line_q, line_d, hits_q, hits_d, hits_inc;
  logic                     stopped_q, stopped_d;
  logic                     eq_all, window_hit, append, close, hit_now, matched;

  always_comb begin
    win_shift[0] = byte_i;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_shift[k] = win_q[k-1];
    end
  end

  assign bil_inc = (bil_q < BilW'(PATTERN_MAX)) ? bil_q + BilW'(1) : bil_q;

  always_comb begin
    eq_all = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (lsm_pkg::LenW'(k) < cfg_i.plen &&
          lsm_pkg::fold(win_shift[k], cfg_i.ign_case) != cfg_i.pat_al[k]) begin
        eq_all = 1'b0;
      end
    end
  end

  assign window_hit = (cfg_i.plen != '0) && (lsm_pkg::LenW'(bil_inc) >= cfg_i.plen) && eq_all;

  assign append  = fire_i && !stopped_q && byte_i != lsm_pkg::CharNul
                   && byte_i != lsm_pkg::CharNl;
  assign close   = fire_i && !stopped_q &&
                   ((byte_i == lsm_pkg::CharNul && bil_q != '0) ||
                    byte_i == lsm_pkg::CharNl || (append && last_i));
  assign hit_now = hit_q || (append && window_hit);
  assign matched = hit_now || cfg_i.plen == '0;
  assign hits_inc = (matched && hits_q != lsm_pkg::CntMax) ? hits_q + lsm_pkg::CntW'(1)
                                                           : hits_q;

  assign emit_o             = fire_i && (close || last_i);
  assign res_o.line_valid   = close;
  assign res_o.line_number  = close ? line_q : '0;
  assign res_o.line_matched = close && matched;
  assign res_o.hit_count    = close ? hits_inc : hits_q;
  assign res_o.end_of_file  = last_i;

  always_comb begin
    win_d     = win_q;
    bil_d     = bil_q;
    hit_d     = hit_q;
    line_d    = line_q;
    hits_d    = hits_q;
    stopped_d = stopped_q;
    if (fire_i) begin
      if (append) begin
        win_d = win_shift;
        bil_d = bil_inc;
        hit_d = hit_now;
      end
      if (close) begin
        bil_d  = '0;
        hit_d  = 1'b0;
        hits_d = hits_inc;
        line_d = (line_q != lsm_pkg::CntMax) ? line_q + lsm_pkg::CntW'(1) : line_q;
      end
      if (!stopped_q && byte_i == lsm_pkg::CharNul) begin
        stopped_d = 1'b1;
      end
      // end of file: back to the reset state for the next file
      if (last_i) begin
        win_d     = '0;
        bil_d     = '0;
        hit_d     = 1'b0;
        line_d    = lsm_pkg::CntW'(1);
        hits_d    = '0;
        stopped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      bil_q     <= '0;
      hit_q     <= 1'b0;
      line_q    <= lsm_pkg::CntW'(1);
      hits_q    <= '0;
      stopped_q <= 1'b0;
    end else begin
      win_q     <= win_d;
      bil_q     <= bil_d;
      hit_q     <= hit_d;
      line_q    <= line_d;
      hits_q    <= hits_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

// ===== rtl/core/line_substring_matcher.sv =====
// line_substring_matcher: top level with input register, scanner and result register
// depends on lsm_pkg, lsm_cfg and lsm_scan
//
// Usage: file bytes enter on the s_axis channel, one item per byte, tdata holding
// the byte and tlast marking the final byte of the file. For every byte that
// closes a line (newline, a zero byte after a non-empty line, or the final byte)
// one item leaves on m_axis; the final byte always gives an item, with tlast set,
// even when it closes no line (then tuser is 0 and the hit count is the total).
// Bytes that close nothing give no item, and after a zero byte the rest of the
// file is skipped until the final byte.
// Pipeline: two register stages, the input register and the result register; the
// result of an accepted byte enters the result register when that register can
// advance. Throughput is one byte per cycle while m_axis_tready does not stall the
// output, set by the line state update and the parallel compare at all window positions.
// When an item waits and m_axis_tready is low, the result register holds and the
// input register fills, after which s_axis_tready drops; no item is lost or repeated.
// Reset clears the pattern registers, the line counter (to one), the hit
// count and the window. The pattern is set over the APB port at byte addresses
// 0 (bytes 0-7), 8 (bytes 8-15), 16 (length) and 24 (ignore case) while idle.
module line_substring_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
  input  logic                      s_axis_tlast,   // last_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [71:0]               m_axis_tdata,   // [31:0] line_number, [32] line_matched,
                                                    // [64:33] hit_count, [71:65] zero
  output logic                      m_axis_tuser,   // line_valid
  output logic                      m_axis_tlast,   // end_of_file
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsm_pkg::AddrW-1:0] paddr,
  input  logic [lsm_pkg::RegW-1:0]  pwdata,
  output logic [lsm_pkg::RegW-1:0]  prdata,
  output logic                      pready
);

  lsm_pkg::lsm_cfg_t         cfg;
  lsm_pkg::lsm_result_t      res, out_q;
  logic                      s1_valid_q, s1_last_q, out_valid_q;
  logic [lsm_pkg::ByteW-1:0] s1_byte_q;
  logic                      advance, fire, emit;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign fire          = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  lsm_cfg #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  lsm_scan #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.hit_count, out_q.line_matched, out_q.line_number};
  assign m_axis_tuser  = out_q.line_valid;
  assign m_axis_tlast  = out_q.end_of_file;

endmodule

// ===== tb/sv/lsm_line_checker.sv =====
// lsm_line_checker: watches the byte, result and apb channels of the line substring matcher,
// predicts each result item from its own line state and compares it field by field
// depends on lsm_pkg
module lsm_line_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic                      s_ready_i,
  input  logic [7:0]                s_data_i,
  input  logic                      s_last_i,
  input  logic                      m_valid_i,
  input  logic                      m_ready_i,
  input  logic [71:0]               m_data_i,
  input  logic                      m_user_i,
  input  logic                      m_last_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [lsm_pkg::AddrW-1:0] paddr_i,
  input  logic [lsm_pkg::RegW-1:0]  pwdata_i,
  input  logic                      pready_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               bytes_o,
  output int unsigned               files_o,
  output int unsigned               lines_o,
  output int unsigned               hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the pattern registers
  logic [63:0]                 pat_low_q;
  logic [63:0]                 pat_high_q;
  logic [4:0]                  pat_len_q;
  logic                        ign_q;

  // line state, window newest byte at index 0
  logic [15:0][7:0]            window_q;
  int unsigned                 line_fill;
  bit                          line_hit;
  logic [lsm_pkg::CntW-1:0]    line_no;
  logic [lsm_pkg::CntW-1:0]    hit_total;
  bit                          scan_halted;

  lsm_pkg::lsm_result_t        line_results_q [$];
  int unsigned                 mismatches = 0;
  int unsigned                 byte_total = 0;
  int unsigned                 file_total = 0;
  int unsigned                 line_total = 0;
  int unsigned                 hit_lines  = 0;

  assign fail_count_o = mismatches;
  assign bytes_o      = byte_total;
  assign files_o      = file_total;
  assign lines_o      = line_total;
  assign hits_o       = hit_lines;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (ign_q && c inside {[8'h41:8'h5A]}) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic int unsigned pat_span();
    return (pat_len_q > lsm_pkg::PatBytes) ? lsm_pkg::PatBytes : int'(pat_len_q);
  endfunction

  task automatic restart_file();
    window_q    = '0;
    line_fill   = 0;
    line_hit    = 1'b0;
    line_no     = 1;
    hit_total   = '0;
    scan_halted = 1'b0;
  endtask

  task automatic shift_in(input logic [7:0] b);
    int unsigned      span;
    logic [127:0]     pat;
    bit               same;
    span     = pat_span();
    pat      = {pat_high_q, pat_low_q};
    window_q = {window_q[14:0], b};
    if (line_fill < lsm_pkg::PatBytes) line_fill++;
    if (span != 0 && line_fill >= span) begin
      same = 1'b1;
      // window position span-1-j holds the byte lined up with pattern byte j
      for (int j = 0; j < span; j++) begin
        if (to_lower(window_q[span-1-j]) != to_lower(pat[j*8 +: 8])) same = 1'b0;
      end
      if (same) line_hit = 1'b1;
    end
  endtask

  task automatic close_line(output lsm_pkg::lsm_result_t r);
    bit hit;
    hit = line_hit || pat_span() == 0;
    if (hit && hit_total != lsm_pkg::CntMax) hit_total++;
    r.line_valid   = 1'b1;
    r.line_number  = line_no;
    r.line_matched = hit;
    r.hit_count    = hit_total;
    r.end_of_file  = 1'b0;
    if (line_no != lsm_pkg::CntMax) line_no++;
    line_fill = 0;
    line_hit  = 1'b0;
    line_total++;
    if (hit) hit_lines++;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic lst);
    lsm_pkg::lsm_result_t r;
    bit                   made;
    r    = '0;
    made = 1'b0;
    byte_total++;
    if (!scan_halted) begin
      if (b == lsm_pkg::CharNul) begin
        if (line_fill != 0) begin
          close_line(r);
          made = 1'b1;
        end
        scan_halted = 1'b1;
      end else if (b == lsm_pkg::CharNl) begin
        close_line(r);
        made = 1'b1;
      end else begin
        shift_in(b);
        if (lst) begin
          close_line(r);
          made = 1'b1;
        end
      end
    end
    if (lst) begin
      // final byte always reports, even with no line closed
      if (!made) begin
        r           = '0;
        r.hit_count = hit_total;
      end
      r.end_of_file = 1'b1;
      made          = 1'b1;
      file_total++;
      restart_file();
    end
    if (made) line_results_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    lsm_pkg::lsm_result_t want;
    if (line_results_q.size() == 0) begin
      $error("result item with no line pending: line_number %0d, end_of_file %0b",
             m_data_i[31:0], m_last_i);
      mismatches++;
    end else begin
      want = line_results_q.pop_front();
      compare_field("line_valid", 32'(want.line_valid), 32'(m_user_i));
      compare_field("line_number", want.line_number, m_data_i[31:0]);
      compare_field("line_matched", 32'(want.line_matched), 32'(m_data_i[32]));
      compare_field("hit_count", want.hit_count, m_data_i[64:33]);
      compare_field("end_of_file", 32'(want.end_of_file), 32'(m_last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  = '0;
      pat_high_q = '0;
      pat_len_q  = '0;
      ign_q      = 1'b0;
      restart_file();
      line_results_q.delete();
      pending_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) check_result();
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (lsm_pkg::lsm_reg_e'(paddr_i[4:3]))
          lsm_pkg::RegPatLow:  pat_low_q  = pwdata_i;
          lsm_pkg::RegPatHigh: pat_high_q = pwdata_i;
          lsm_pkg::RegPatLen:  pat_len_q  = pwdata_i[4:0];
          lsm_pkg::RegIgnCase: ign_q      = pwdata_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) take_byte(s_data_i, s_last_i);
      pending_o <= line_results_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_line_substring_matcher.sv =====
// tb_line_substring_matcher: drives byte streams and pattern settings into the matcher,
// with bursty input and a stalling result side; depends on lsm_pkg, the matcher rtl
// and lsm_line_checker, which does all prediction and comparison
module tb_line_substring_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  // characters around the case-folding boundaries plus a few plain letters
  localparam logic [11:0][7:0] ProbeChars = {
    8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h5B,
    8'h60, 8'h7B, 8'h62, 8'h42, 8'h63, 8'h43
  };
  localparam int unsigned HoldCycles = 80;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata;   // [7:0] data_byte
  logic                      s_axis_tlast;   // last_byte
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [71:0]               m_axis_tdata;   // [31:0] line_number, [32] line_matched,
                                             // [64:33] hit_count, [71:65] zero
  logic                      m_axis_tuser;   // line_valid
  logic                      m_axis_tlast;   // end_of_file
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [lsm_pkg::AddrW-1:0] paddr;
  logic [lsm_pkg::RegW-1:0]  pwdata;
  logic [lsm_pkg::RegW-1:0]  prdata;
  logic                      pready;

  int unsigned       failures;
  int unsigned       pending;
  int unsigned       bytes_seen;
  int unsigned       files_seen;
  int unsigned       lines_seen;
  int unsigned       hits_seen;

  int unsigned       sent       = 0;
  int unsigned       burst_left = 0;
  int unsigned       pat_used   = 0;
  int unsigned       settings   = 0;
  bit                steady     = 1'b0;
  bit                fold_on    = 1'b0;
  bit                hold_req   = 1'b0;
  logic [127:0]      pat_bits   = '0;

  line_substring_matcher #(
    .PATTERN_MAX(16)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lsm_line_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .m_last_i     (m_axis_tlast),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (failures),
    .pending_o    (pending),
    .bytes_o      (bytes_seen),
    .files_o      (files_seen),
    .lines_o      (lines_seen),
    .hits_o       (hits_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[line_substring_matcher] ERROR");
    $finish;
  end

  // result side: random ready patterns, and one long hold-off when asked
  initial begin : result_sink
    int unsigned seg;
    int unsigned mode;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        seg  = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        repeat (seg) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 5) != 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic apb_write(input lsm_pkg::lsm_reg_e r, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic program_pattern(input logic [127:0] pat, input logic [4:0] len,
                                 input bit ign);
    // unused upper bits carry noise, the block keeps only the low ones
    apb_write(lsm_pkg::RegPatLow, pat[63:0]);
    apb_write(lsm_pkg::RegPatHigh, pat[127:64]);
    apb_write(lsm_pkg::RegPatLen, {27'($urandom), 32'($urandom), len});
    apb_write(lsm_pkg::RegIgnCase, {31'($urandom), 32'($urandom), ign});
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    pat_bits = pat;
    pat_used = (len > lsm_pkg::PatBytes) ? lsm_pkg::PatBytes : int'(len);
    fold_on  = ign;
    settings++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        s_axis_tlast  <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    sent++;
  endtask

  task automatic send_str(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], mark_last && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] pat_char(input int unsigned j);
    logic [7:0] c;
    c = pat_bits[j*8 +: 8];
    // flip letter case, often when folding is on, now and then when it is off
    if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]} &&
        $urandom_range(0, 99) < (fold_on ? 50 : 10)) begin
      c = c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] text_byte();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c = ProbeChars[$urandom_range(0, 11)];
    end else if (pick < 85 && pat_used != 0) begin
      c = pat_char($urandom_range(0, pat_used - 1));
    end else begin
      c = 8'($urandom_range(1, 255));
    end
    if (c == lsm_pkg::CharNl || c == lsm_pkg::CharNul) c = 8'h2E;
    return c;
  endfunction

  function automatic logic [127:0] make_pattern();
    logic [127:0] p;
    for (int i = 0; i < 16; i++) begin
      p[i*8 +: 8] = ($urandom_range(0, 9) < 7) ? ProbeChars[$urandom_range(0, 11)]
                                               : 8'($urandom_range(1, 255));
    end
    return p;
  endfunction

  // one line of text, often holding the pattern or a near miss of it
  task automatic send_line(input bit close_nl, input bit mark_last);
    logic [7:0]  text [$];
    int unsigned len;
    int unsigned lead;
    int unsigned span;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    lead = $urandom_range(0, len);
    for (int i = 0; i < lead; i++) text.push_back(text_byte());
    if (pat_used != 0 && $urandom_range(0, 99) < 45) begin
      span = pat_used;
      if (span > 1 && $urandom_range(0, 4) == 0) span--;
      for (int j = 0; j < span; j++) text.push_back(pat_char(j));
    end
    for (int i = lead; i < len; i++) text.push_back(text_byte());
    if (mark_last && !close_nl && text.size() == 0) text.push_back(text_byte());
    foreach (text[i]) begin
      send_byte(text[i], mark_last && !close_nl && i == text.size() - 1);
    end
    if (close_nl) send_byte(lsm_pkg::CharNl, mark_last);
  endtask

  task automatic send_file();
    int unsigned lines;
    lines = $urandom_range(0, 5);
    repeat (lines) send_line(1'b1, 1'b0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_line(1'b1, 1'b1);
      4, 5, 6, 7: send_line(1'b0, 1'b1);
      8: begin
        // zero byte stops the scan, the tail up to the final byte is skipped
        send_line(1'($urandom_range(0, 1)), 1'b0);
        send_byte(lsm_pkg::CharNul, 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        send_line(1'b0, 1'b0);
        send_byte(lsm_pkg::CharNul, 1'b1);
      end
    endcase
  endtask

  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [127:0] pat, input logic [4:0] len, input bit ign,
                           input int unsigned budget, input bit press);
    int unsigned stop_at;
    await_idle();
    program_pattern(pat, len, ign);
    if (press) begin
      steady   = 1'b1;
      hold_req = 1'b1;
    end else begin
      steady = ($urandom_range(0, 3) == 0);
    end
    stop_at = sent + budget;
    while (sent < stop_at) send_file();
  endtask

  initial begin : stimulus
    logic [127:0] odd_pat;
    int unsigned  odd_len;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pattern "Ab" with case folding
    program_pattern(128'h6241, 5'd2, 1'b1);
    send_str("xaB\n", 1'b0);
    send_str("\n", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_str("ab\n", 1'b0);
    // zero byte closes a non-empty line, then the rest is skipped
    send_str("Q", 1'b0);
    send_byte(lsm_pkg::CharNul, 1'b0);
    send_str("ab\n", 1'b0);
    send_byte(8'h7A, 1'b1);
    // zero byte on an empty line, final byte closes nothing
    send_byte(lsm_pkg::CharNul, 1'b0);
    send_byte(lsm_pkg::CharNul, 1'b1);
    send_str("ab\n", 1'b1);
    send_str("zab", 1'b1);

    run_phase(make_pattern(), 5'd3, 1'b1, 150, 1'b0);
    run_phase('0, 5'd0, 1'b0, 100, 1'b0);
    run_phase(make_pattern(), 5'd16, 1'b0, 170, 1'b1);
    run_phase(make_pattern(), 5'd16, 1'b1, 170, 1'b0);
    run_phase(make_pattern(), 5'd1, 1'b0, 120, 1'b0);
    run_phase('1, 5'd31, 1'b1, 120, 1'b0);
    run_phase(make_pattern(), 5'($urandom_range(17, 30)), 1'($urandom_range(0, 1)),
              120, 1'b0);
    // pattern holding a zero or newline byte can never match
    odd_len = $urandom_range(2, 6);
    odd_pat = make_pattern();
    odd_pat[8*$urandom_range(0, odd_len - 1) +: 8] =
      $urandom_range(0, 1) ? lsm_pkg::CharNl : lsm_pkg::CharNul;
    run_phase(odd_pat, 5'(odd_len), 1'($urandom_range(0, 1)), 100, 1'b0);
    repeat (3) begin
      run_phase(make_pattern(), 5'($urandom_range(2, 15)), 1'($urandom_range(0, 1)),
                100, 1'b0);
    end
    await_idle();

    $display("scanned %0d bytes in %0d files under %0d pattern settings",
             bytes_seen, files_seen, settings);
    $display("%0d lines closed, %0d of them contained the pattern", lines_seen, hits_seen);
    if (failures == 0) begin
      $display("[line_substring_matcher] OK");
    end else begin
      $display("[line_substring_matcher] ERROR");
    end
    $finish;
  end

endmodule
